/* rtl/piecewise_linear_interpolator_top_macros.svh */
// Assertion macros used by the interpolator back part.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PLI_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define PLI_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define PLI_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define PLI_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

/* rtl/pli_pkg.sv */
// Shared types and constants of the interpolator.
package pli_pkg;
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] idx;
    logic [31:0]      ex;
    logic [31:0]      ey;
    logic [31:0]      qx;
  } pli_item_t;
endpackage

/* rtl/pli_queue.sv */
// Two-entry queue between the front and the back.
module pli_queue import pli_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  pli_item_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output pli_item_t rd_data
);
  pli_item_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

/* rtl/pli_front.sv */
// Front part: accepts input transfers and unpacks them into queue items.
module pli_front import pli_pkg::*; (
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,
  input  logic [103:0] in_tdata,
  output logic        q_valid,
  input  logic        q_ready,
  output pli_item_t   q_data
);
  assign in_tready = q_ready;
  assign q_valid = in_tvalid;
  always_comb begin
    q_data.cmd = in_tuser;
    q_data.idx = in_tdata[IDX_W-1:0];
    q_data.ex = in_tdata[39:8];
    q_data.ey = in_tdata[71:40];
    q_data.qx = in_tdata[103:72];
  end
endmodule

/* rtl/pli_back.sv */
// Back part: table memory, binary search, serial divide and multiply.
module pli_back import pli_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] n_cfg,
  input  logic             q_valid,
  output logic             q_ready,
  input  pli_item_t        q_data,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [39:0]      out_tdata,
  output logic [1:0]       out_tuser
);
  `include "piecewise_linear_interpolator_top_macros.svh"

  localparam logic [3:0] S_IDLE = 4'd0, S_SRCH = 4'd1, S_SWAIT = 4'd2,
    S_RD0 = 4'd3, S_RD1 = 4'd4, S_RD2 = 4'd5, S_PREP = 4'd6, S_DIV = 4'd7,
    S_MUL = 4'd8, S_FIN = 4'd9, S_OUT = 4'd10;

  logic [31:0] xm [TABLE_DEPTH];
  logic [31:0] ym [TABLE_DEPTH];
  logic [3:0] st_r;
  logic [CNT_W-1:0] lo_r, hi_r;
  logic [IDX_W-1:0] ra_r;
  logic [31:0] xrd_r, yrd_r;
  logic [31:0] qx_r, xl_r, xr_r, yl_r, yr_r;
  logic [48:0] num_r;
  logic [33:0] den_r;
  logic [34:0] rem_r;
  logic [48:0] mt_r;
  logic [5:0] k_r;
  logic [32:0] mdy_r;
  logic [81:0] p_r;
  logic negp_r;
  logic [31:0] res_r;
  logic sat_r, zero_r;
  logic [CNT_W-1:0] n_eff, mid;
  logic [33:0] w, dx, dy;
  logic [34:0] rsh;
  logic [34:0] rdiff;
  logic signed [34:0] sres;
  logic [33:0] corr;

  assign q_ready = st_r == S_IDLE;
  assign mid = (lo_r + hi_r) >> 1;

  always_comb begin
    n_eff = n_cfg;
    if (n_cfg < CNT_W'(2)) n_eff = CNT_W'(2);
    if (n_cfg > CNT_W'(TABLE_DEPTH)) n_eff = CNT_W'(TABLE_DEPTH);
    w = {{2{xr_r[31]}}, xr_r} - {{2{xl_r[31]}}, xl_r};
    dx = {{2{qx_r[31]}}, qx_r} - {{2{xl_r[31]}}, xl_r};
    dy = {{2{yr_r[31]}}, yr_r} - {{2{yl_r[31]}}, yl_r};
    rsh = {rem_r[33:0], num_r[48]};
    rdiff = rsh - {1'b0, den_r};
    corr = negp_r ? 34'(-(p_r[81:16] + {65'd0, |p_r[15:0]})) : p_r[49:16];
    sres = $signed({{3{yl_r[31]}}, yl_r}) + $signed({corr[33], corr});
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready && q_data.cmd == CMD_LOAD) begin
      xm[q_data.idx] <= q_data.ex;
      ym[q_data.idx] <= q_data.ey;
    end
    xrd_r <= xm[ra_r];
    yrd_r <= ym[ra_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_tvalid <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (q_valid && q_data.cmd == CMD_QUERY) begin
            qx_r <= q_data.qx;
            lo_r <= '0;
            hi_r <= n_eff - CNT_W'(1);
            k_r <= '0;
            st_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (hi_r - lo_r > CNT_W'(1)) begin
            ra_r <= mid[IDX_W-1:0];
            st_r <= S_SWAIT;
          end else begin
            ra_r <= lo_r[IDX_W-1:0];
            st_r <= S_RD0;
          end
        end
        S_SWAIT: begin
          if (k_r[0]) begin
            if ($signed(xrd_r) <= $signed(qx_r)) lo_r <= mid;
            else hi_r <= mid;
            k_r <= '0;
            st_r <= S_SRCH;
          end else begin
            k_r <= 6'd1;
          end
        end
        S_RD0: begin
          ra_r <= IDX_W'(lo_r + CNT_W'(1));
          st_r <= S_RD1;
        end
        S_RD1: begin
          xl_r <= xrd_r;
          yl_r <= yrd_r;
          st_r <= S_RD2;
        end
        S_RD2: begin
          xr_r <= xrd_r;
          yr_r <= yrd_r;
          st_r <= S_PREP;
        end
        S_PREP: begin
          sat_r <= 1'b0;
          zero_r <= 1'b0;
          if (w == '0) begin
            zero_r <= 1'b1;
            res_r <= yl_r;
            st_r <= S_OUT;
            out_tvalid <= 1'b1;
          end else begin
            num_r <= {(dx[33] ? 33'(-dx) : dx[32:0]), 16'd0};
            den_r <= w[33] ? -w : w;
            negp_r <= dx[33] ^ w[33] ^ dy[33];
            mdy_r <= dy[33] ? 33'(-dy) : dy[32:0];
            rem_r <= '0;
            mt_r <= '0;
            k_r <= '0;
            st_r <= S_DIV;
          end
        end
        S_DIV: begin
          num_r <= num_r << 1;
          if (!rdiff[34]) begin
            rem_r <= rdiff;
            mt_r <= {mt_r[47:0], 1'b1};
          end else begin
            rem_r <= rsh;
            mt_r <= {mt_r[47:0], 1'b0};
          end
          k_r <= k_r + 6'd1;
          if (k_r == 6'd48) begin
            k_r <= '0;
            p_r <= '0;
            st_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (mt_r[k_r[5:0]]) p_r <= p_r + (82'(mdy_r) << k_r);
          k_r <= k_r + 6'd1;
          if (k_r == 6'd48) st_r <= S_FIN;
        end
        S_FIN: begin
          if (p_r[81:62] != '0 && !(p_r[81:62] == 20'd1 && p_r[61:0] == '0)) begin
            sat_r <= 1'b1;
            res_r <= negp_r ? 32'h8000_0000 : 32'h7fff_ffff;
          end else if (p_r[81:49] != '0 || sres > 35'sd2147483647
                       || sres < -35'sd2147483648) begin
            sat_r <= 1'b1;
            res_r <= (negp_r ? 32'h8000_0000 : 32'h7fff_ffff);
          end else begin
            res_r <= sres[31:0];
          end
          out_tvalid <= 1'b1;
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) begin
            out_tvalid <= 1'b0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tdata = {lo_r[IDX_W-1:0], res_r};
  assign out_tuser = {zero_r, sat_r};

  `PLI_ASSERT_IMP(a_vld_st, clk, rst_n, out_tvalid, st_r == S_OUT, "valid outside output state")
  `PLI_ASSERT_IMP(a_rdy, clk, rst_n, q_ready, !out_tvalid, "ready while result pending")
  `PLI_ASSERT_IMP(a_bnd, clk, rst_n, st_r == S_SRCH, hi_r > lo_r, "search bounds crossed")
  `PLI_ASSERT_IMP(a_zs, clk, rst_n, out_tvalid, !(zero_r && sat_r), "zero width saturated")
endmodule

/* rtl/piecewise_linear_interpolator_top.sv */
// A query raises its result after up to eight search probes on the single table read port,
// a 49-step restoring divide and a 49-step shift-add multiply. A zero-width segment skips
// the divide and multiply. A load is written into the table when the idle back part takes
// it from the queue. The back part handles one item at a time and a two-entry queue holds
// the next ones, so the input stalls once the queue is full while a query is in progress.
module piecewise_linear_interpolator_top import pli_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [8:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tuser,    // command
  input  logic [103:0] in_tdata,    // entry_index, entry_x, entry_y, query_x
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,   // result_y, segment_index
  output logic [1:0]   out_tuser    // saturated, zero_interval
);
  logic [8:0] cnt_r;
  logic fv, fr, bv, br;
  pli_item_t fd, bd;

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 9'd2;
    else if (cfg_we) cnt_r <= cfg_wdata;
  end

  pli_front u_f (.in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .q_valid(fv), .q_ready(fr), .q_data(fd));
  pli_queue u_q (.clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fd),
    .rd_valid(bv), .rd_ready(br), .rd_data(bd));
  pli_back u_b (.clk, .rst_n, .n_cfg(cnt_r), .q_valid(bv), .q_ready(br), .q_data(bd),
    .out_tvalid, .out_tready, .out_tdata, .out_tuser);
endmodule
